FILE: rtl/core/blitter_line_draw_step_core_defines.svh
// Assertion macros for the line-draw step core.
// Pulled in by the files that carry concurrent assertions; depends on nothing.
`ifndef BLITTER_LINE_DRAW_STEP_CORE_DEFINES_SVH
`define BLITTER_LINE_DRAW_STEP_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define BLD_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define BLD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/bld_pkg.sv
// Shared types, constants and helper functions for the line-draw step core.
// Used by bld_step, bld_rsp_q and blitter_line_draw_step_core; no dependencies.
package bld_pkg;

   localparam int ADDR_BITS    = 21;   // internal address wrap width
   localparam int OUT_ADDR_W   = 21;   // address width on the result port
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 36;
   localparam int LEN_W        = 11;
   localparam int DEPTH_RSP    = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ERROR_INIT    = 3'd0,
      CSR_MOD_A         = 3'd1,
      CSR_MOD_B         = 3'd2,
      CSR_ROW_MODULO    = 3'd3,
      CSR_START_ADDRESS = 3'd4,
      CSR_DOT_WORDS     = 3'd5,
      CSR_PATTERN_WORDS = 3'd6,
      CSR_CONTROL_WORD  = 3'd7
   } csr_index_type;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] read_data;
   } req_payload_type;

   typedef struct packed {
      logic                  write_enable;
      logic [OUT_ADDR_W-1:0] access_address;
      logic [15:0]           write_data;
      logic [OUT_ADDR_W-1:0] next_address;
      logic signed [15:0]    line_error;
      logic                  zero_flag;
      logic                  done_res;
      logic                  ignored;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [15:0] error_init;
      logic signed [15:0] mod_a;
      logic signed [15:0] mod_b;
      logic signed [15:0] row_modulo;
      logic [20:0]        start_address;
      logic [31:0]        dot_words;
      logic [35:0]        pattern_words;
      logic [29:0]        control_word;
   } cfg_regs_type;

   typedef struct packed {
      logic [15:0]          error_acc;
      logic [15:0]          texture;
      logic [ADDR_BITS-1:0] cur_address;
      logic [LEN_W-1:0]     step_count;
      logic [3:0]           bit_pos;
      logic                 row_dot_done;
      logic                 all_zero;
      logic                 error_neg;
      logic                 started;
   } line_state_type;

   // rotate a 16-bit word right by s
   function automatic logic [15:0] rotr16(input logic [15:0] v, input logic [3:0] s);
      logic [31:0] dbl;
      dbl = {v, v} >> s;
      return dbl[15:0];
   endfunction

   // 8-bit minterm: bit {a,b,c} of mt selects each result bit
   function automatic logic [15:0] minterm(input logic [7:0] mt, input logic [15:0] a,
                                           input logic [15:0] b, input logic [15:0] c);
      logic [15:0] d;
      for (int i = 0; i < 16; i++) begin
         d[i] = mt[{a[i], b[i], c[i]}];
      end
      return d;
   endfunction

endpackage

FILE: rtl/core/blitter_line_draw_step_core.sv
// Line-draw blitter step core: takes one request per cycle while not stalled and returns
// one result per request, in the next cycle when the result channel is free. A start
// request (action 0) loads the line from the configuration registers; each step request
// brings the destination word read at the current address and returns the minterm word,
// its write strobe, the address handled, the next address and the updated error term. The
// whole step is one pass of combinational logic between the line state registers and a
// two-entry result queue, so the sustained rate is one request per clock; the queue lets
// a new request in while a finished result still waits, and req_ready drops only when
// both entries are held. Configuration writes are always ready and are taken live by
// the following requests. Depends on bld_pkg, bld_step, bld_rsp_q and the defines header.
`include "blitter_line_draw_step_core_defines.svh"

module blitter_line_draw_step_core
   import bld_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_data,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_data,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_regs_type    cfg_ff, cfg_in;
   line_state_type  state_ff, state_in, state_calc;
   rsp_payload_type rsp_calc;
   logic            q_full;
   logic            req_fire;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign req_fire  = req_valid && req_ready;

   // register file decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ERROR_INIT:    cfg_in.error_init    = csr_data[15:0];
            CSR_MOD_A:         cfg_in.mod_a         = csr_data[15:0];
            CSR_MOD_B:         cfg_in.mod_b         = csr_data[15:0];
            CSR_ROW_MODULO:    cfg_in.row_modulo    = csr_data[15:0];
            CSR_START_ADDRESS: cfg_in.start_address = csr_data[20:0];
            CSR_DOT_WORDS:     cfg_in.dot_words     = csr_data[31:0];
            CSR_PATTERN_WORDS: cfg_in.pattern_words = csr_data[35:0];
            CSR_CONTROL_WORD:  cfg_in.control_word  = csr_data[29:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // one step of the line per accepted request
   bld_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (req_data),
      .nxt (state_calc),
      .rsp (rsp_calc)
   );

   assign state_in = req_fire ? state_calc : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{all_zero: 1'b1, default: '0};
      end else begin
         state_ff <= state_in;
      end
   end

   // results wait here so the request side keeps moving
   bld_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_data (rsp_calc),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ignored steps leave the line untouched
   `BLD_ASSERT_NEXT(a_ignored_holds, clock, reset, req_fire && rsp_calc.ignored,
      $stable(state_ff), "ignored step changed the line state")

   // a start always leaves a fresh line behind
   `BLD_ASSERT_NEXT(a_start_loads, clock, reset,
      req_fire && (req_data.action == ACTION_START),
      state_ff.started && (state_ff.step_count == '0) && state_ff.all_zero,
      "start request did not load a fresh line")

   // once started, only reset clears the started flag
   `BLD_ASSERT_IMPLIES(a_started_sticks, clock, reset, 1'b1, !$fell(state_ff.started),
      "started flag dropped without reset")

   // back pressure only with results pending
   `BLD_ASSERT_IMPLIES(a_stall_has_rsp, clock, reset, !req_ready, rsp_valid,
      "request side stalled with no pending result")

endmodule

FILE: rtl/core/bld_step.sv
// Combinational step datapath: next line state and result for one request.
// Depends on bld_pkg.
module bld_step
   import bld_pkg::*;
(
   input  cfg_regs_type    cfg,
   input  line_state_type  cur,
   input  req_payload_type req,
   output line_state_type  nxt,
   output rsp_payload_type rsp
);

   // x move: bit position walks, address moves one word at the wrap
   function automatic logic [ADDR_BITS+3:0] move_x(input logic [ADDR_BITS-1:0] addr,
                                                   input logic [3:0] bp, input logic dec);
      logic [ADDR_BITS-1:0] a;
      logic [3:0]           b;
      a = addr;
      if (dec) begin
         b = bp - 4'd1;
         if (bp == 4'd0) a = addr - ADDR_BITS'(2);
      end else begin
         b = bp + 4'd1;
         if (b == 4'd0) a = addr + ADDR_BITS'(2);
      end
      return {a, b};
   endfunction

   function automatic logic [ADDR_BITS-1:0] move_y(input logic [ADDR_BITS-1:0] addr,
                                                  input logic [ADDR_BITS-1:0] ofs,
                                                  input logic dec);
      return dec ? addr - ofs : addr + ofs;
   endfunction

   logic [7:0]            mt;
   logic [2:0]            oct;
   logic                  one_dot, use_a, use_c, sign_init;
   logic [3:0]            start_bit;
   logic [LEN_W-1:0]      length;
   logic [ADDR_BITS-1:0]  row_ofs;
   logic [15:0]           a_word, b_word, c_word, d_word;
   logic                  done_cur;
   logic [ADDR_BITS+3:0]  xy1, xy2;
   logic [15:0]           err_sum;

   assign mt        = cfg.control_word[7:0];
   assign oct       = cfg.control_word[10:8];
   assign one_dot   = cfg.control_word[11];
   assign use_a     = cfg.control_word[12];
   assign use_c     = cfg.control_word[13];
   assign sign_init = cfg.control_word[14];
   assign start_bit = cfg.control_word[18:15];
   assign length    = cfg.control_word[29:19];
   assign row_ofs   = {{(ADDR_BITS-16){cfg.row_modulo[15]}}, cfg.row_modulo};

   assign a_word   = (cfg.dot_words[31:16] & cfg.dot_words[15:0]) >> cur.bit_pos;
   assign b_word   = cur.texture[0] ? 16'hFFFF : 16'h0000;
   assign c_word   = use_c ? req.read_data : cfg.pattern_words[31:16];
   assign d_word   = minterm(mt, a_word, b_word, c_word);
   assign done_cur = cur.started && (cur.step_count >= length);
   assign err_sum  = cur.error_acc + (cur.error_neg ? cfg.mod_b : cfg.mod_a);

   // octant moves: optional major move on a clear sign, then the minor move
   always_comb begin
      xy1 = {cur.cur_address, cur.bit_pos};
      if (oct[2]) begin
         if (!cur.error_neg) xy1[ADDR_BITS+3:4] = move_y(cur.cur_address, row_ofs, oct[1]);
         xy2 = move_x(xy1[ADDR_BITS+3:4], xy1[3:0], oct[0]);
      end else begin
         if (!cur.error_neg) xy1 = move_x(cur.cur_address, cur.bit_pos, oct[1]);
         xy2 = {move_y(xy1[ADDR_BITS+3:4], row_ofs, oct[0]), xy1[3:0]};
      end
   end

   always_comb begin
      nxt                = cur;
      rsp.write_enable   = 1'b0;
      rsp.write_data     = 16'h0000;
      rsp.ignored        = 1'b0;
      rsp.access_address = OUT_ADDR_W'(cur.cur_address);
      if (req.action == ACTION_START) begin
         nxt.error_acc      = cfg.error_init;
         nxt.texture        = rotr16(cfg.pattern_words[15:0], cfg.pattern_words[35:32]);
         nxt.cur_address    = ADDR_BITS'(cfg.start_address);
         nxt.step_count     = '0;
         nxt.bit_pos        = start_bit;
         nxt.row_dot_done   = 1'b0;
         nxt.all_zero       = 1'b1;
         nxt.error_neg      = sign_init;
         nxt.started        = 1'b1;
         rsp.access_address = OUT_ADDR_W'(nxt.cur_address);
      end else if (!cur.started || done_cur) begin
         rsp.ignored = 1'b1;
      end else begin
         rsp.write_data   = d_word;
         rsp.write_enable = use_c && (!one_dot || !cur.row_dot_done);
         nxt.all_zero     = cur.all_zero && (d_word == 16'h0000);
         nxt.step_count   = cur.step_count + LEN_W'(1);
         nxt.error_acc    = use_a ? err_sum : cur.error_acc;
         nxt.error_neg    = nxt.error_acc[15];
         nxt.cur_address  = xy2[ADDR_BITS+3:4];
         nxt.bit_pos      = xy2[3:0];
         // a row move clears the one-dot latch
         nxt.row_dot_done = oct[2] && cur.error_neg;
         nxt.texture      = {cur.texture[14:0], cur.texture[15]};
      end
      rsp.next_address = OUT_ADDR_W'(nxt.cur_address);
      rsp.line_error   = nxt.error_acc;
      rsp.zero_flag    = nxt.all_zero;
      rsp.done_res     = nxt.started && (nxt.step_count >= length);
   end

endmodule

FILE: rtl/core/bld_rsp_q.sv
// Two-entry result queue between the step logic and the result channel.
// Depends on bld_pkg.
module bld_rsp_q
   import bld_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type push_data,
   output logic            full,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   rsp_payload_type entry_ff [DEPTH_RSP];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'(DEPTH_RSP));
   assign rsp_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule
